// ===== rtl/dbc_pkg.sv =====
// Shared definitions for the decimal blink code generator.
// Holds operation codes, sizes and the controller/datapath interface structs.
// No dependencies.
package dbc_pkg;

	localparam int VALUE_W     = 20;
	localparam int PERIOD_W    = 16;
	localparam int DIGITS      = 6;
	localparam int BCD_W       = 4 * DIGITS;
	localparam int CONV_STEPS  = VALUE_W;
	localparam int CNT_W       = $clog2(CONV_STEPS);
	localparam int IDX_W       = $clog2(DIGITS);
	localparam int SLOT_W      = 5;
	localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(999999);

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;

	typedef struct packed {
		logic load;
		logic shift;
		logic begin_play;
		logic show;
		logic tick;
		logic stop;
		logic out_load;
	} dbc_cmd_t;

	typedef struct packed {
		logic value_ok;
		logic conv_last;
	} dbc_status_t;

endpackage

// ===== rtl/decimal_blink_code_generator.sv =====
// Top level of the decimal blink code generator.
// Joins the controller and the datapath; depends on dbc_pkg, dbc_ctrl, dbc_datapath.
//
// Every input word gives exactly one result word: the drive level and the busy flag after
// the word has taken effect. A tick, a cancel, an unused operation code or a start with a
// value above 999999 is answered straight from the idle state. An accepted start steps
// through a load, the bit-serial binary to decimal conversion (one value bit per cycle),
// the playback setup and the showing of the first slot. Results go through an output
// register. While a result waits unread the input is held off, and the next word can be
// taken at the earliest in the cycle in which the waiting result is read.
module decimal_blink_code_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [dbc_pkg::VALUE_W-1:0]  value,
	input  logic [dbc_pkg::PERIOD_W-1:0] period,
	input  logic                         repeat_flag,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         output_level,
	output logic                         busy_res
);

	dbc_pkg::dbc_cmd_t    cmd;
	dbc_pkg::dbc_status_t status;

	dbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dbc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.period       (period),
		.repeat_flag  (repeat_flag),
		.cmd          (cmd),
		.status       (status),
		.output_level (output_level),
		.busy_res     (busy_res)
	);

endmodule

// ===== rtl/dbc_ctrl.sv =====
// Controller for the decimal blink code generator.
// Sequences accept, conversion, playback setup and result hand-off.
// Depends on dbc_pkg.
module dbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          operation,
	output logic                out_valid,
	input  logic                out_ready,
	input  dbc_pkg::dbc_status_t status,
	output dbc_pkg::dbc_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CONV  = 2'd1;
	localparam logic [1:0] ST_BEGIN = 2'd2;
	localparam logic [1:0] ST_SHOW  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_ok;
	logic       accept;

	assign out_ok    = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_ok;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.tick = (operation == dbc_pkg::OP_TICK);
					cmd.stop = (operation == dbc_pkg::OP_START) ||
						(operation == dbc_pkg::OP_CANCEL);
					if ((operation == dbc_pkg::OP_START) && status.value_ok) begin
						cmd.load = 1'b1;
						state_d  = ST_CONV;
					end else begin
						cmd.out_load = 1'b1;
					end
				end
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				if (status.conv_last) begin
					state_d = ST_BEGIN;
				end
			end
			ST_BEGIN: begin
				cmd.begin_play = 1'b1;
				state_d        = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_ok) begin
					cmd.show     = 1'b1;
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/dbc_datapath.sv =====
// Datapath for the decimal blink code generator.
// Binary to decimal conversion, slot sequencer, tick counter and result register.
// Depends on dbc_pkg.
module dbc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [dbc_pkg::VALUE_W-1:0]       value,
	input  logic [dbc_pkg::PERIOD_W-1:0]      period,
	input  logic                              repeat_flag,
	input  dbc_pkg::dbc_cmd_t                 cmd,
	output dbc_pkg::dbc_status_t              status,
	output logic                              output_level,
	output logic                              busy_res
);

	logic [dbc_pkg::VALUE_W-1:0]  bin_q;
	logic [dbc_pkg::BCD_W-1:0]    bcd_q;
	logic [dbc_pkg::CNT_W-1:0]    cnt_q;
	logic [dbc_pkg::PERIOD_W-1:0] period_q;
	logic [dbc_pkg::PERIOD_W-1:0] tc_q;
	logic                         loop_q;
	logic                         running_q;
	logic                         drive_q;
	logic [dbc_pkg::IDX_W-1:0]    start_idx_q;
	logic                         start_trl_q;
	logic [dbc_pkg::IDX_W-1:0]    idx_q;
	logic                         trl_q;
	logic [dbc_pkg::SLOT_W-1:0]   k_q;
	logic                         res_level_q;
	logic                         res_busy_q;

	logic [dbc_pkg::BCD_W-1:0]    bcd_adj;
	logic [3:0]                   dd;
	logic [dbc_pkg::IDX_W-1:0]    lead_idx;
	logic                         lead_any;
	logic [3:0]                   dig;
	logic [3:0]                   dcnt;
	logic                         level;
	logic                         seg_end;
	logic                         pat_end;
	logic [dbc_pkg::PERIOD_W-1:0] tc_dec;
	logic                         show_go;
	logic                         running_d;
	logic                         drive_d;
	logic [dbc_pkg::PERIOD_W-1:0] tc_d;
	logic [dbc_pkg::IDX_W-1:0]    idx_d;
	logic                         trl_d;
	logic [dbc_pkg::SLOT_W-1:0]   k_d;

	assign status.value_ok  = (value <= dbc_pkg::VALUE_MAX);
	assign status.conv_last = (cnt_q == dbc_pkg::CNT_W'(dbc_pkg::CONV_STEPS - 1));
	assign output_level     = res_level_q;
	assign busy_res         = res_busy_q;

	always_comb begin
		bcd_adj  = bcd_q;
		lead_idx = '0;
		lead_any = 1'b0;
		for (int i = 0; i < dbc_pkg::DIGITS; i++) begin
			dd = bcd_q[4*i +: 4];
			if (dd >= 4'd5) begin
				bcd_adj[4*i +: 4] = dd + 4'd3;
			end
			if (dd != 4'd0) begin
				lead_idx = dbc_pkg::IDX_W'(i);
				lead_any = 1'b1;
			end
		end
	end

	always_comb begin
		dig = 4'd0;
		for (int i = 0; i < dbc_pkg::DIGITS; i++) begin
			if (idx_q == dbc_pkg::IDX_W'(i)) begin
				dig = bcd_q[4*i +: 4];
			end
		end
	end

	assign dcnt    = (dig == 4'd0) ? 4'd10 : dig;
	assign level   = trl_q ? (k_q < 5'd2) : ((k_q < {dcnt, 1'b0}) && !k_q[0]);
	assign seg_end = trl_q ? (k_q == 5'd3) : (k_q == {dcnt, 1'b1});
	assign pat_end = trl_q && (k_q == 5'd3);
	assign tc_dec  = (tc_q != '0) ? tc_q - 1'b1 : tc_q;
	assign show_go = cmd.show || (cmd.tick && running_q && (tc_dec == '0));

	always_comb begin
		running_d = running_q;
		drive_d   = drive_q;
		tc_d      = tc_q;
		idx_d     = idx_q;
		trl_d     = trl_q;
		k_d       = k_q;
		if (cmd.stop) begin
			running_d = 1'b0;
			drive_d   = 1'b0;
		end
		if (cmd.tick && running_q) begin
			tc_d = tc_dec;
		end
		if (cmd.begin_play) begin
			running_d = 1'b1;
			idx_d     = lead_idx;
			trl_d     = !lead_any;
			k_d       = '0;
		end
		if (show_go) begin
			drive_d = level;
			if (pat_end && !loop_q) begin
				running_d = 1'b0;
				drive_d   = 1'b0;
			end else begin
				tc_d = period_q;
				if (pat_end) begin
					idx_d = start_idx_q;
					trl_d = start_trl_q;
					k_d   = '0;
				end else if (seg_end) begin
					k_d = '0;
					if (idx_q == '0) begin
						trl_d = 1'b1;
					end else begin
						idx_d = idx_q - 1'b1;
					end
				end else begin
					k_d = k_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			drive_q   <= 1'b0;
			tc_q      <= '0;
			loop_q    <= 1'b0;
		end else begin
			running_q <= running_d;
			drive_q   <= drive_d;
			tc_q      <= tc_d;
			if (cmd.load) begin
				loop_q <= repeat_flag;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		trl_q <= trl_d;
		k_q   <= k_d;
		if (cmd.load) begin
			bin_q    <= value;
			bcd_q    <= '0;
			cnt_q    <= '0;
			period_q <= (period == '0) ? dbc_pkg::PERIOD_W'(1) : period;
		end else if (cmd.shift) begin
			{bcd_q, bin_q} <= {bcd_adj[dbc_pkg::BCD_W-2:0], bin_q, 1'b0};
			cnt_q          <= cnt_q + 1'b1;
		end
		if (cmd.begin_play) begin
			start_idx_q <= lead_idx;
			start_trl_q <= !lead_any;
		end
		if (cmd.out_load) begin
			res_level_q <= drive_d;
			res_busy_q  <= running_d;
		end
	end

endmodule
